/* rtl/subtractive_lagged_random_macros.svh */
// ----------------------------------------------------------------------------
// Subtractive lagged random generator: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SUBTRACTIVE_LAGGED_RANDOM_MACROS_SVH
`define SUBTRACTIVE_LAGGED_RANDOM_MACROS_SVH

// antecedent holds in the same cycle as the consequent
`define SLR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define SLR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/slr_pkg.sv */
// ----------------------------------------------------------------------------
// Subtractive lagged random generator: package
// Ring geometry, seeding constants, types and modular helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

   localparam int RingDepth = 55;
   localparam int IdxW      = 6;
   localparam int ValW      = 30;
   localparam int SeedW     = 29;
   localparam int Passes    = 4;
   localparam int PassW     = 2;

   typedef logic [IdxW-1:0]  idx_type;
   typedef logic [ValW-1:0]  val_type;
   typedef logic [SeedW-1:0] seed_type;
   typedef logic [PassW-1:0] pass_type;

   localparam val_type  ModBig    = 30'd1000000000;
   localparam seed_type SeedBase  = 29'd161803398;
   localparam idx_type  LagStart  = 6'd31;
   localparam idx_type  FillStep  = 6'd21;
   localparam idx_type  LastIdx   = idx_type'(RingDepth - 1);
   localparam idx_type  FillLast  = idx_type'(RingDepth - 2);
   localparam pass_type PassLast  = pass_type'(Passes - 1);

   typedef struct packed {
      logic    rd_en;
      idx_type ra;
      idx_type rb;
      logic    wr_en;
      idx_type wa;
      logic    wr_diff;
      val_type wdata;
   } ring_cmd_type;

   // (a - b) mod 1e9 for a, b below 1e9
   function automatic val_type sub_mod(input val_type a, input val_type b);
      logic [ValW:0] t;
      begin
         if (a >= b) begin
            t = {1'b0, a} - {1'b0, b};
         end else begin
            t = {1'b0, a} + {1'b0, ModBig} - {1'b0, b};
         end
         return t[ValW-1:0];
      end
   endfunction

   // (a + b) mod 55 for a, b below 55
   function automatic idx_type idx_add(input idx_type a, input idx_type b);
      logic [IdxW:0] s;
      begin
         s = {1'b0, a} + {1'b0, b};
         if (s >= (IdxW+1)'(RingDepth)) begin
            s = s - (IdxW+1)'(RingDepth);
         end
         return s[IdxW-1:0];
      end
   endfunction

   function automatic idx_type idx_inc(input idx_type a);
      return (a == LastIdx) ? '0 : idx_type'(a + idx_type'(1));
   endfunction

endpackage

`default_nettype wire

/* rtl/subtractive_lagged_random.sv */
// ----------------------------------------------------------------------------
// Subtractive lagged random generator: top level
// Each req item is one draw; each draw returns one rsp item.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready carry a signed 29-bit seed per draw. A negative seed,
//   or the first draw after reset, rebuilds the 55-entry ring from the seed
//   magnitude (saturated at 161803398) before drawing.
//   rsp_valid/rsp_ready return rsp_value (0..999999999, units of 1e-9) and
//   rsp_reseeded, set when that draw rebuilt the ring.
// Timing:
//   A plain draw issues both ring reads in StDrawRd; in StDrawWr the read
//   data arrives and the subtract, write back and output register load
//   happen, waiting while a stalled rsp holds the output register. One draw
//   is in flight at a time, so a new draw is accepted only after the last
//   one has loaded the output register. A rebuild adds 1 start write, 54 fill
//   writes and 4 passes of 55 read-then-write steps over the single ring memory.
// Reset clears the initialized flag, the ring positions and rsp_valid; the
//   ring contents are not cleared. A stalled rsp holds its item while the
//   next req is accepted; the following draw waits for the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "subtractive_lagged_random_macros.svh"

module subtractive_lagged_random
   import slr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic signed [SeedW-1:0] req_seed,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [ValW-1:0]              rsp_value,
   output logic                         rsp_reseeded
);

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StSeed   = 3'd1;
   localparam logic [2:0] StFill   = 3'd2;
   localparam logic [2:0] StStirRd = 3'd3;
   localparam logic [2:0] StStirWr = 3'd4;
   localparam logic [2:0] StDrawRd = 3'd5;
   localparam logic [2:0] StDrawWr = 3'd6;

   logic [2:0]   state_ff,    state_in;
   logic         inited_ff,   inited_in;
   idx_type      rd_idx_ff,   rd_idx_in;
   idx_type      lag_idx_ff,  lag_idx_in;
   pass_type     pass_ff,     pass_in;
   idx_type      slot_ff,     slot_in;
   idx_type      fill_cnt_ff, fill_cnt_in;
   val_type      k_ff,        k_in;
   val_type      j_ff,        j_in;
   val_type      start_ff,    start_in;
   logic         reseed_ff,   reseed_in;
   logic         rsp_valid_ff, rsp_valid_in;
   val_type      rsp_value_ff, rsp_value_in;
   logic         rsp_reseeded_ff, rsp_reseeded_in;

   ring_cmd_type ring_cmd;
   val_type      ring_diff;
   seed_type     seed_mag;
   seed_type     seed_sat;
   idx_type      lag_expect;
   logic         stir_done;
   logic         pos_home;
   logic         wr_clean;

   slr_ring u_ring (
      .clock   (clock),
      .cmd     (ring_cmd),
      .rd_diff (ring_diff)
   );

   assign req_ready    = (state_ff == StIdle);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_reseeded = rsp_reseeded_ff;

   assign seed_mag   = req_seed[SeedW-1] ? seed_type'(-req_seed) : seed_type'(req_seed);
   assign seed_sat   = (seed_mag > SeedBase) ? SeedBase : seed_mag;
   assign lag_expect = idx_add(rd_idx_ff, LagStart);

   always_comb begin
      state_in        = state_ff;
      inited_in       = inited_ff;
      rd_idx_in       = rd_idx_ff;
      lag_idx_in      = lag_idx_ff;
      pass_in         = pass_ff;
      slot_in         = slot_ff;
      fill_cnt_in     = fill_cnt_ff;
      k_in            = k_ff;
      j_in            = j_ff;
      start_in        = start_ff;
      reseed_in       = reseed_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_value_in    = rsp_value_ff;
      rsp_reseeded_in = rsp_reseeded_ff;
      ring_cmd        = '0;

      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               reseed_in = req_seed[SeedW-1] || !inited_ff;
               start_in  = val_type'(SeedBase - seed_sat);
               state_in  = (req_seed[SeedW-1] || !inited_ff) ? StSeed : StDrawRd;
            end
         end
         StSeed: begin
            ring_cmd.wr_en = 1'b1;
            ring_cmd.wa    = LastIdx;
            ring_cmd.wdata = start_ff;
            k_in           = val_type'(1);
            j_in           = start_ff;
            slot_in        = FillStep;
            fill_cnt_in    = '0;
            state_in       = StFill;
         end
         StFill: begin
            ring_cmd.wr_en = 1'b1;
            ring_cmd.wa    = slot_ff - idx_type'(1);
            ring_cmd.wdata = k_ff;
            k_in           = sub_mod(j_ff, k_ff);
            j_in           = k_ff;
            slot_in        = idx_add(slot_ff, FillStep);
            fill_cnt_in    = fill_cnt_ff + idx_type'(1);
            if (fill_cnt_ff == FillLast) begin
               rd_idx_in  = '0;
               lag_idx_in = LagStart;
               pass_in    = '0;
               state_in   = StStirRd;
            end
         end
         StStirRd: begin
            ring_cmd.rd_en = 1'b1;
            ring_cmd.ra    = rd_idx_ff;
            ring_cmd.rb    = lag_idx_ff;
            state_in       = StStirWr;
         end
         StStirWr: begin
            ring_cmd.wr_en   = 1'b1;
            ring_cmd.wr_diff = 1'b1;
            ring_cmd.wa      = rd_idx_ff;
            rd_idx_in        = idx_inc(rd_idx_ff);
            lag_idx_in       = idx_inc(lag_idx_ff);
            state_in         = StStirRd;
            if (rd_idx_ff == LastIdx) begin
               pass_in = pass_ff + pass_type'(1);
               if (pass_ff == PassLast) begin
                  inited_in = 1'b1;
                  state_in  = StDrawRd;
               end
            end
         end
         StDrawRd: begin
            ring_cmd.rd_en = 1'b1;
            ring_cmd.ra    = rd_idx_ff;
            ring_cmd.rb    = lag_idx_ff;
            state_in       = StDrawWr;
         end
         StDrawWr: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ring_cmd.wr_en   = 1'b1;
               ring_cmd.wr_diff = 1'b1;
               ring_cmd.wa      = rd_idx_ff;
               rd_idx_in        = idx_inc(rd_idx_ff);
               lag_idx_in       = idx_inc(lag_idx_ff);
               rsp_valid_in     = 1'b1;
               rsp_value_in     = ring_diff;
               rsp_reseeded_in  = reseed_ff;
               state_in         = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         inited_ff    <= 1'b0;
         rd_idx_ff    <= '0;
         lag_idx_ff   <= LagStart;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inited_ff    <= inited_in;
         rd_idx_ff    <= rd_idx_in;
         lag_idx_ff   <= lag_idx_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff         <= slot_in;
      fill_cnt_ff     <= fill_cnt_in;
      k_ff            <= k_in;
      j_ff            <= j_in;
      start_ff        <= start_in;
      reseed_ff       <= reseed_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_reseeded_ff <= rsp_reseeded_in;
   end

   assign stir_done = (state_ff == StStirWr) && (state_in == StDrawRd);
   assign pos_home  = (rd_idx_ff == '0) && (lag_idx_ff == LagStart);
   assign wr_clean  = !ring_cmd.rd_en && (ring_cmd.wa <= LastIdx);

   `SLR_ASSERT_IMP(a_lag_distance, 1'b1, lag_idx_ff == lag_expect, "lag position drifted")
   `SLR_ASSERT_IMP(a_draw_inited, state_ff == StDrawRd, inited_ff, "draw before ring built")
   `SLR_ASSERT_NEXT(a_stir_end_pos, stir_done, pos_home, "positions not restored after stir")
   `SLR_ASSERT_IMP(a_no_rw_overlap, ring_cmd.wr_en, wr_clean, "ring write overlaps read")
   `SLR_ASSERT_IMP(a_rsp_source, $rose(rsp_valid_ff), $past(state_ff) == StDrawWr, "stray rsp item")

endmodule

`default_nettype wire

/* rtl/slr_ring.sv */
// ----------------------------------------------------------------------------
// Subtractive lagged random generator: ring memory
// 55-entry table with two registered read ports, one write port and the
// modular subtractor on the read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slr_ring
   import slr_pkg::*;
(
   input  wire logic         clock,
   input  wire ring_cmd_type cmd,
   output val_type           rd_diff
);

   val_type ring_mem [RingDepth];
   val_type rd_a_ff;
   val_type rd_b_ff;
   val_type wr_data;

   assign rd_diff = sub_mod(rd_a_ff, rd_b_ff);
   assign wr_data = cmd.wr_diff ? rd_diff : cmd.wdata;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         ring_mem[cmd.wa] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= ring_mem[cmd.ra];
         rd_b_ff <= ring_mem[cmd.rb];
      end
   end

endmodule

`default_nettype wire
